// ----- hw/rtl/ist_pkg.sv -----
// ist_pkg: shared types and constants for the integer set table
// holds opcode codes, field widths and the per-cell control struct
// no dependencies
`default_nettype none

package ist_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 5;

    // operation codes; the spare code behaves as a query
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    // what a cell does with its entry in the update cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_BELOW,
        CELL_LOAD_ABOVE
    } cell_op_t;

    typedef struct packed {
        logic     cmp_en;
        cell_op_t op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/integer_set_table.sv -----
// integer_set_table: top level of the fixed-capacity signed integer set
// depends on ist_pkg and ist_cell
//
// The set lives in a row of CAPACITY cells, one entry per cell, with the
// live entries packed into the lowest cells below the occupancy count.
// Each transfer carries an opcode (add, remove, query; the spare code acts
// as a query) and a value, and yields exactly one result: whether the value
// was present before, the count afterwards and a status that flags an add
// refused because the set is full. In the cycle the input transfer happens
// every cell compares the value against its entry and registers a hit; in
// the update state that follows the hits are combined and the row updates.
// An add shifts every entry up one cell and drops the new
// value into cell 0; a remove shifts the cells at and above the match down
// one cell, closing the gap. The result sits in an output register; while
// it is stalled and not yet taken, the next item is held in its update
// state. The input is stalled until an item has updated, so a new item is
// taken only once the last is through. The entries need no clearing after
// reset: only cells below the count ever take part in a compare.
`default_nettype none

module integer_set_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ist_pkg::OP_W-1:0]      opcode,
    input  wire logic signed [ist_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               was_present,
    output logic [ist_pkg::COUNT_W-1:0]        count,
    output logic                               status
);
    import ist_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic out_valid_reg, out_valid_next;
    logic was_present_reg, was_present_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic status_reg, status_next;

    // captured item
    logic [OP_W-1:0] op_reg;
    value_t          value_reg;

    // cell row
    value_t        cell_entry [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] shift_mask;
    cell_ctrl_t    cell_ctrl [CAPACITY];

    logic in_xfer;
    logic upd_go;
    logic found;
    logic do_add;
    logic do_remove;
    logic add_full;
    logic [OCC_W+COUNT_W-1:0] count_wide;

    assign in_xfer = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // update goes ahead once the output register is free or being emptied
    assign upd_go = (state_reg == ST_UPDATE) && !(out_valid_reg && out_stall);

    // entries are unique, so at most one hit; cells at and above it shift
    assign found      = |hit_vec;
    assign shift_mask = ~(hit_vec - CAPACITY'(1));

    assign do_add    = (op_reg == OP_ADD) && !found && (occ_reg < OCC_W'(CAPACITY));
    assign add_full  = (op_reg == OP_ADD) && !found && (occ_reg >= OCC_W'(CAPACITY));
    assign do_remove = (op_reg == OP_REMOVE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            value_t below_data;
            value_t above_data;
            logic   occupied;

            if (gi == 0)
            begin : g_first
                assign below_data = value_reg;
            end
            else
            begin : g_mid
                assign below_data = cell_entry[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign above_data = cell_entry[gi];
            end
            else
            begin : g_inner
                assign above_data = cell_entry[gi+1];
            end

            assign occupied = (occ_reg > OCC_W'(gi));

            always_comb
            begin
                cell_ctrl[gi].cmp_en = in_xfer;
                priority if (upd_go && do_add)
                    cell_ctrl[gi].op = CELL_LOAD_BELOW;
                else if (upd_go && do_remove && shift_mask[gi])
                    cell_ctrl[gi].op = CELL_LOAD_ABOVE;
                else
                    cell_ctrl[gi].op = CELL_HOLD;
            end

            ist_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl[gi]),
                .probe    (value),
                .occupied (occupied),
                .below    (below_data),
                .above    (above_data),
                .entry    (cell_entry[gi]),
                .hit      (hit_vec[gi])
            );
        end
    endgenerate

    // item capture for the update cycle
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= opcode;
            value_reg <= value;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        out_valid_next   = out_valid_reg && out_stall;
        was_present_next = was_present_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        count_wide       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (upd_go)
                begin
                    priority if (do_add)
                        occ_next = occ_reg + OCC_W'(1);
                    else if (do_remove)
                        occ_next = occ_reg - OCC_W'(1);
                    else
                        occ_next = occ_reg;
                    // count carries the low bits of the occupancy
                    count_wide       = {{COUNT_W{1'b0}}, occ_next};
                    state_next       = ST_IDLE;
                    out_valid_next   = 1'b1;
                    was_present_next = found;
                    count_next       = count_wide[COUNT_W-1:0];
                    status_next      = add_full ? STATUS_FULL : STATUS_OK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            occ_reg         <= '0;
            out_valid_reg   <= 1'b0;
            was_present_reg <= 1'b0;
            count_reg       <= '0;
            status_reg      <= STATUS_OK;
        end
        else
        begin
            state_reg       <= state_next;
            occ_reg         <= occ_next;
            out_valid_reg   <= out_valid_next;
            was_present_reg <= was_present_next;
            count_reg       <= count_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign was_present = was_present_reg;
    assign count       = count_reg;
    assign status      = status_reg;

    // an accepted item always moves on to its update cycle
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_UPDATE))
        else $error("accepted item did not reach update");

    // a value is never stored twice, so compares hit at most one cell
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $onehot0(hit_vec))
        else $error("more than one cell matched");

    // occupancy stays within capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    // occupancy only moves in an update that produces a result
    a_occ_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !upd_go |=> $stable(occ_reg))
        else $error("occupancy changed outside an update");

endmodule

`default_nettype wire

// ----- hw/rtl/ist_cell.sv -----
// ist_cell: one slot of the set, holding a single entry and its match flag
// depends on ist_pkg for value and control types
`default_nettype none

module ist_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ist_pkg::cell_ctrl_t ctrl,
    input  wire ist_pkg::value_t     probe,
    input  wire logic                occupied,
    input  wire ist_pkg::value_t     below,
    input  wire ist_pkg::value_t     above,
    output ist_pkg::value_t          entry,
    output logic                     hit
);
    import ist_pkg::*;

    value_t entry_reg;
    value_t entry_next;
    logic   hit_reg;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_LOAD_BELOW: entry_next = below;
            CELL_LOAD_ABOVE: entry_next = above;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // match against the probe, only for live slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            hit_reg <= occupied && (probe == entry_reg);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire
